// ===== rtl/akf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, reset values and helpers of the angle Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int unsigned CfgW       = 31;
    localparam int unsigned DataW      = 32;
    localparam logic [CfgW-1:0] ApnReset = 31'd16777;
    localparam logic [CfgW-1:0] BpnReset = 31'd50332;
    localparam logic [CfgW-1:0] MnReset  = 31'd503316;

    typedef enum logic [1:0] {
        REG_APN = 2'd0,
        REG_BPN = 2'd1,
        REG_MN  = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_INNER,
        S_Y,
        S_MUL_ISSUE,
        S_MUL_WAIT,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_DT_RATE,
        OP_DT_BB,
        OP_DT_INNER,
        OP_BPN_DT,
        OP_K0_Y,
        OP_K1_Y,
        OP_K0_A,
        OP_K0_B,
        OP_K1_A,
        OP_K1_B
    } t_mul_op;

    typedef struct packed {
        logic              start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic signed [31:0] num;
        logic signed [32:0] den;
    } t_div_req;

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/angle_kalman_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_kalman_filter_top
// Two-state (angle, gyro bias) Kalman filter in Q16.16 / Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Input transfer: i_in_valid with angle, rate and time step; o_in_stall is
// high while an item is being filtered. Output transfer: o_out_valid with
// o_angle_estimate, held while i_out_stall is high. One result per item.
// Each item runs through a sequencer that shares one bit-serial multiplier
// (ten products, each with its issue step) and one restoring divider (two
// gains; no iterations when the innovation variance is zero), plus four
// steps of its own: rate, inner, innovation and output. Between items the
// sequencer returns to its idle step before it takes the next transfer.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds a finished item only at its final step.
// Noise registers sit on the APB port at 0x0, 0x4, 0x8; the user must write
// them only while the block is idle; it is not enforced. Reset clears the state
// and covariance to zero and loads the noise registers with their defaults.
// ----------------------------------------------------------------------------
module angle_kalman_filter_top
    import akf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_measured_angle,
    input  logic signed [31:0] i_measured_rate,
    input  logic [15:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_angle_estimate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    t_state  r_state, n_state;
    t_mul_op r_op, n_op;
    logic    r_div_sel, n_div_sel;
    logic [CfgW-1:0] r_apn, r_bpn, r_mn;
    logic signed [31:0] r_ma, n_ma;
    logic signed [31:0] r_mr, n_mr;
    logic [15:0]        r_dt, n_dt;
    logic signed [31:0] r_rate, n_rate, r_t, n_t, r_inner, n_inner;
    logic signed [31:0] r_k0, n_k0, r_k1, n_k1, r_y, n_y, r_a, n_a, r_b, n_b;
    logic signed [31:0] r_ang, n_ang, r_bias, n_bias;
    logic signed [31:0] r_aa, n_aa, r_ab, n_ab, r_ba, n_ba, r_bb, n_bb;
    logic               r_ov, n_ov;
    logic signed [31:0] r_oe, n_oe;
    t_mul_req mul_req;
    t_div_req div_req;
    logic               mul_done, div_done;
    logic signed [63:0] prod;
    logic signed [31:0] quot;
    logic signed [65:0] p16, p24;
    logic signed [31:0] dt_s;
    t_reg_idx widx;
    logic     wr_en;

    akf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req),
        .o_done(mul_done), .o_prod(prod)
    );

    akf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(quot)
    );

    // configuration
    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= ApnReset;
            r_bpn <= BpnReset;
            r_mn  <= MnReset;
        end else if (wr_en) begin
            unique case (widx)
                REG_APN: r_apn <= pwdata[CfgW-1:0];
                REG_BPN: r_bpn <= pwdata[CfgW-1:0];
                REG_MN:  r_mn  <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_APN: prdata = {1'b0, r_apn};
            REG_BPN: prdata = {1'b0, r_bpn};
            REG_MN:  prdata = {1'b0, r_mn};
            default: prdata = '0;
        endcase
    end

    assign dt_s = $signed({16'd0, r_dt});
    assign p16  = 66'(prod >>> 16);
    assign p24  = 66'(prod >>> 24);

    // operand select of the shared multiplier and the divider
    always_comb begin
        mul_req.start = (r_state == S_MUL_ISSUE);
        case (r_op)
            OP_DT_RATE:  begin mul_req.a = dt_s; mul_req.b = r_rate; end
            OP_DT_BB:    begin mul_req.a = dt_s; mul_req.b = r_bb; end
            OP_DT_INNER: begin mul_req.a = dt_s; mul_req.b = r_inner; end
            OP_BPN_DT:   begin mul_req.a = $signed({1'b0, r_bpn}); mul_req.b = dt_s; end
            OP_K0_Y:     begin mul_req.a = r_k0; mul_req.b = r_y; end
            OP_K1_Y:     begin mul_req.a = r_k1; mul_req.b = r_y; end
            OP_K0_A:     begin mul_req.a = r_k0; mul_req.b = r_a; end
            OP_K0_B:     begin mul_req.a = r_k0; mul_req.b = r_b; end
            OP_K1_A:     begin mul_req.a = r_k1; mul_req.b = r_a; end
            default:     begin mul_req.a = r_k1; mul_req.b = r_b; end
        endcase
        div_req.start = (r_state == S_DIV_ISSUE);
        div_req.num   = r_div_sel ? r_ba : r_aa;
        div_req.den   = 33'(r_aa) + $signed({2'b00, r_mn});
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_div_sel = r_div_sel;
        n_ma = r_ma; n_mr = r_mr; n_dt = r_dt;
        n_rate = r_rate; n_t = r_t; n_inner = r_inner;
        n_k0 = r_k0; n_k1 = r_k1; n_y = r_y; n_a = r_a; n_b = r_b;
        n_ang = r_ang; n_bias = r_bias;
        n_aa = r_aa; n_ab = r_ab; n_ba = r_ba; n_bb = r_bb;
        n_ov = r_ov && i_out_stall;
        n_oe = r_oe;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ma = i_measured_angle;
                    n_mr = i_measured_rate;
                    n_dt = i_time_step;
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_rate  = f_sat32(66'(r_mr) - 66'(r_bias));
                n_op    = OP_DT_RATE;
                n_state = S_MUL_ISSUE;
            end
            S_INNER: begin
                n_inner = f_sat32(66'(r_t) - 66'(r_ab) - 66'(r_ba)
                                  + $signed({35'd0, r_apn}));
                n_ab    = f_sat32(66'(r_ab) - 66'(r_t));
                n_ba    = f_sat32(66'(r_ba) - 66'(r_t));
                n_op    = OP_DT_INNER;
                n_state = S_MUL_ISSUE;
            end
            S_Y: begin
                n_y     = f_sat32(66'(r_ma) - 66'(r_ang));
                n_a     = r_aa;
                n_b     = r_ab;
                n_op    = OP_K0_Y;
                n_state = S_MUL_ISSUE;
            end
            S_MUL_ISSUE: n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = S_MUL_ISSUE;
                    case (r_op)
                        OP_DT_RATE: begin
                            n_ang = f_sat32(66'(r_ang) + p16);
                            n_op  = OP_DT_BB;
                        end
                        OP_DT_BB: begin
                            n_t     = f_sat32(p16);
                            n_state = S_INNER;
                        end
                        OP_DT_INNER: begin
                            n_aa = f_sat32(66'(r_aa) + p16);
                            n_op = OP_BPN_DT;
                        end
                        OP_BPN_DT: begin
                            n_bb      = f_sat32(66'(r_bb) + p16);
                            n_div_sel = 1'b0;
                            n_state   = S_DIV_ISSUE;
                        end
                        OP_K0_Y: begin
                            n_ang = f_sat32(66'(r_ang) + p24);
                            n_op  = OP_K1_Y;
                        end
                        OP_K1_Y: begin
                            n_bias = f_sat32(66'(r_bias) + p24);
                            n_op   = OP_K0_A;
                        end
                        OP_K0_A: begin
                            n_aa = f_sat32(66'(r_aa) - p24);
                            n_op = OP_K0_B;
                        end
                        OP_K0_B: begin
                            n_ab = f_sat32(66'(r_ab) - p24);
                            n_op = OP_K1_A;
                        end
                        OP_K1_A: begin
                            n_ba = f_sat32(66'(r_ba) - p24);
                            n_op = OP_K1_B;
                        end
                        default: begin
                            n_bb    = f_sat32(66'(r_bb) - p24);
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV_ISSUE: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_div_sel) begin
                        n_k1    = quot;
                        n_state = S_Y;
                    end else begin
                        n_k0      = quot;
                        n_div_sel = 1'b1;
                        n_state   = S_DIV_ISSUE;
                    end
                end
            end
            S_OUT: begin
                if (!(r_ov && i_out_stall)) begin
                    n_ov    = 1'b1;
                    n_oe    = r_ang;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_ang   <= '0;
            r_bias  <= '0;
            r_aa    <= '0;
            r_ab    <= '0;
            r_ba    <= '0;
            r_bb    <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_ang   <= n_ang;
            r_bias  <= n_bias;
            r_aa    <= n_aa;
            r_ab    <= n_ab;
            r_ba    <= n_ba;
            r_bb    <= n_bb;
        end
        r_op <= n_op; r_div_sel <= n_div_sel;
        r_ma <= n_ma; r_mr <= n_mr; r_dt <= n_dt;
        r_rate <= n_rate; r_t <= n_t; r_inner <= n_inner;
        r_k0 <= n_k0; r_k1 <= n_k1; r_y <= n_y; r_a <= n_a; r_b <= n_b;
        r_oe <= n_oe;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_angle_estimate = r_oe;

    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_MUL_WAIT)
        else $error("multiplier finished outside its wait step");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait step");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without a finished item");
endmodule

// ===== rtl/akf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_mul
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module akf_mul
    import akf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic signed [63:0] o_prod
);
    logic [31:0] r_a, n_a;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic        r_neg, n_neg;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] sum;
    logic [63:0] mag;

    always_comb begin
        n_a    = r_a;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        sum    = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 33'd0);
        if (i_req.start) begin
            n_a    = i_req.a[31] ? 32'(-i_req.a) : 32'(i_req.a);
            n_lo   = i_req.b[31] ? 32'(-i_req.b) : 32'(i_req.b);
            n_hi   = '0;
            n_neg  = i_req.a[31] ^ i_req.b[31];
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_hi  = sum[32:1];
            n_lo  = {sum[0], r_lo[31:1]};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_neg <= n_neg;
    end

    assign mag    = {r_hi, r_lo};
    assign o_prod = r_neg ? -$signed(mag) : $signed(mag);
    assign o_done = r_done;
endmodule

// ===== rtl/akf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_div
// Restoring gain divider, 1 bit a cycle: sat(num*2^24/den) truncated; 0 if den 0.
// ----------------------------------------------------------------------------
module akf_div
    import akf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    logic [55:0] r_q, n_q;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_d, n_d;
    logic        r_neg, n_neg;
    logic        r_zero, n_zero;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] shifted;
    logic [31:0] num_mag;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        num_mag = i_req.num[31] ? 32'(-i_req.num) : 32'(i_req.num);
        shifted = {r_rem[32:0], r_q[55]};
        if (i_req.start) begin
            n_q    = {num_mag, 24'd0};
            n_rem  = '0;
            n_d    = i_req.den[32] ? 33'(-i_req.den) : 33'(i_req.den);
            n_neg  = i_req.num[31] ^ i_req.den[32];
            n_zero = (i_req.den == '0);
            n_cnt  = '0;
            if (i_req.den == '0) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + 6'd1;
            if (shifted >= {1'b0, r_d}) begin
                n_rem = shifted - {1'b0, r_d};
                n_q   = {r_q[54:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[54:0], 1'b0};
            end
            if (r_cnt == 6'd55) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = (r_q > 56'h80000000) ? 32'sh8000_0000 : 32'(-r_q);
        end else begin
            o_quot = (r_q > 56'h7FFFFFFF) ? 32'sh7FFF_FFFF : r_q[31:0];
        end
    end
    assign o_done = r_done;
endmodule
